// ----- rtl/core/period_tracking_capture_buffer_defines.svh -----
// assertion macros used by the capture buffer checker
`ifndef PERIOD_TRACKING_CAPTURE_BUFFER_DEFINES_SVH
`define PERIOD_TRACKING_CAPTURE_BUFFER_DEFINES_SVH

// property holds at every sampled edge outside reset
`define PTCB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// condition implies a property in the next cycle
`define PTCB_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- rtl/core/ptcb_pkg.sv -----
// types, constants and helpers of the period tracking capture buffer
package ptcb_pkg;

    localparam int LEN_W    = 17;
    localparam int POS_W    = 16;
    localparam int PHASE_W  = 16;
    localparam int SAMPLE_W = 24;
    localparam int PER_W    = 5;
    localparam int CFG_W    = 17;
    localparam int CFG_IDX_W = 1;

    localparam logic [PHASE_W-1:0] HALF_TURN = 16'd32768;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_PERIODS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_LEN = 1'b1;

    localparam logic [PER_W-1:0] RESET_PERIODS = 5'd1;
    localparam logic [LEN_W-1:0] RESET_LEN     = 17'd256;
    localparam logic [LEN_W-1:0] MIN_LEN       = 17'd2;

    typedef struct packed {
        logic [LEN_W-1:0] length;
        logic [POS_W-1:0] write_pos;
        logic             retriggered;
        logic             rd_hit;
    } step_res_t;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] n,
                                                   input logic [LEN_W-1:0] max_len);
        logic [LEN_W-1:0] r;
        if (n < MIN_LEN) begin
            r = MIN_LEN;
        end else if (n > max_len) begin
            r = max_len;
        end else begin
            r = n;
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/ptcb_ram.sv -----
// generic single write port, single read port ram with registered read
module ptcb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ----- rtl/core/ptcb_pos_mod.sv -----
// multi-cycle remainder unit that folds the write position into a new ring length
module ptcb_pos_mod (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [ptcb_pkg::POS_W-1:0]      dividend,
    input  logic [ptcb_pkg::LEN_W-1:0]      divisor,
    output logic                            busy,
    output logic                            done,
    output logic [ptcb_pkg::POS_W-1:0]      result
);
    import ptcb_pkg::*;

    localparam int DIV_W = LEN_W + POS_W - 1;

    logic [POS_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] div_reg, div_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             sub_ok;
    logic [POS_W-1:0] rem_step;

    always_comb begin
        sub_ok   = {{(DIV_W-POS_W){1'b0}}, rem_reg} >= div_reg;
        rem_step = sub_ok ? (rem_reg - div_reg[POS_W-1:0]) : rem_reg;

        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start) begin
            rem_next  = dividend;
            div_next  = {divisor, {(POS_W-1){1'b0}}};
            cnt_next  = 4'(POS_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // one restoring step per cycle, divisor walks down one bit
            rem_next = rem_step;
            div_next = div_reg >> 1;
            if (cnt_reg == 4'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = rem_reg;
endmodule

// ----- rtl/core/ptcb_ctrl.sv -----
// capture state: wrap detection, retrigger, ring position and store access
module ptcb_ctrl #(
    parameter int MAX_LEN = 65536,
    parameter int AW      = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 step_en,
    input  logic                                 s_cmd,
    input  logic [ptcb_pkg::PHASE_W-1:0]         s_phase,
    input  logic signed [ptcb_pkg::SAMPLE_W-1:0] s_sample,
    input  logic [ptcb_pkg::POS_W-1:0]           s_read_index,
    input  logic                                 cfg_wr_en,
    input  logic [ptcb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ptcb_pkg::CFG_W-1:0]           cfg_wdata,
    output ptcb_pkg::step_res_t                  res,
    output logic                                 busy,
    output logic                                 ram_we,
    output logic [AW-1:0]                        ram_waddr,
    output logic [ptcb_pkg::SAMPLE_W-1:0]        ram_wdata,
    output logic                                 ram_re,
    output logic [AW-1:0]                        ram_raddr
);
    import ptcb_pkg::*;

    localparam logic [LEN_W-1:0] MAX_LEN_V = LEN_W'(MAX_LEN);
    localparam logic [LEN_W-1:0] RST_LEN_V = (RESET_LEN < MAX_LEN_V) ? RESET_LEN : MAX_LEN_V;

    logic [POS_W-1:0]   wp_reg, wp_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [PHASE_W-1:0] prev_reg, prev_next;
    logic [LEN_W-1:0]   cnt_reg, cnt_next;
    logic [PER_W-1:0]   wc_reg, wc_next;
    logic [PER_W-1:0]   per_reg, per_next;

    logic             wrap;
    logic [PER_W-1:0] wc_inc;
    logic             retrig;
    logic [POS_W-1:0] base_pos;
    logic [LEN_W-1:0] base_len;
    logic [LEN_W-1:0] base_cnt;
    logic [LEN_W-1:0] pos_inc;
    logic [POS_W-1:0] pos_wrap;
    logic             rd_hit;
    logic [LEN_W-1:0] cfg_len;
    logic             mod_start;
    logic             mod_busy;
    logic             mod_done;
    logic [POS_W-1:0] mod_result;

    ptcb_pos_mod u_pos_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mod_start),
        .dividend (wp_reg),
        .divisor  (cfg_len),
        .busy     (mod_busy),
        .done     (mod_done),
        .result   (mod_result)
    );

    always_comb begin
        // a wrap is a drop of more than half a turn
        wrap     = (prev_reg > s_phase) && ((prev_reg - s_phase) > HALF_TURN);
        wc_inc   = wc_reg + 5'd1;
        retrig   = wrap && (wc_inc >= per_reg);
        base_pos = retrig ? '0 : wp_reg;
        base_len = retrig ? clamp_len(cnt_reg, MAX_LEN_V) : len_reg;
        base_cnt = retrig ? '0 : cnt_reg;
        pos_inc  = {1'b0, base_pos} + 17'd1;
        pos_wrap = (pos_inc == base_len) ? '0 : pos_inc[POS_W-1:0];
        rd_hit   = {1'b0, s_read_index} < len_reg;
        cfg_len  = clamp_len(cfg_wdata, MAX_LEN_V);

        wp_next   = wp_reg;
        len_next  = len_reg;
        prev_next = prev_reg;
        cnt_next  = cnt_reg;
        wc_next   = wc_reg;
        per_next  = per_reg;
        mod_start = 1'b0;

        if (step_en && (s_cmd == CMD_SAMPLE)) begin
            prev_next = s_phase;
            wc_next   = retrig ? '0 : (wrap ? wc_inc : wc_reg);
            len_next  = base_len;
            cnt_next  = (base_cnt < MAX_LEN_V) ? (base_cnt + 17'd1) : base_cnt;
            wp_next   = pos_wrap;
        end

        if (cfg_wr_en) begin
            case (cfg_index)
                REG_PERIODS: begin
                    per_next = cfg_wdata[PER_W-1:0];
                end
                REG_INIT_LEN: begin
                    len_next  = cfg_len;
                    mod_start = 1'b1;
                end
                default: begin
                end
            endcase
        end

        if (mod_done) begin
            wp_next = mod_result;
        end

        if (s_cmd == CMD_READ) begin
            res.length      = len_reg;
            res.write_pos   = wp_reg;
            res.retriggered = 1'b0;
            res.rd_hit      = rd_hit;
        end else begin
            res.length      = base_len;
            res.write_pos   = pos_wrap;
            res.retriggered = retrig;
            res.rd_hit      = 1'b0;
        end

        ram_we    = step_en && (s_cmd == CMD_SAMPLE);
        ram_waddr = base_pos[AW-1:0];
        ram_wdata = s_sample;
        ram_re    = step_en && (s_cmd == CMD_READ);
        ram_raddr = s_read_index[AW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg   <= '0;
            len_reg  <= RST_LEN_V;
            prev_reg <= '0;
            cnt_reg  <= '0;
            wc_reg   <= '0;
            per_reg  <= RESET_PERIODS;
        end else begin
            wp_reg   <= wp_next;
            len_reg  <= len_next;
            prev_reg <= prev_next;
            cnt_reg  <= cnt_next;
            wc_reg   <= wc_next;
            per_reg  <= per_next;
        end
    end

    assign busy = mod_busy || mod_done;
endmodule

// ----- rtl/core/period_tracking_capture_buffer.sv -----
// top level of the period tracking capture buffer
// Triggered ring capture for a scope view. Each sample beat (s_cmd low) is
// written into a ring of the current length; a read beat (s_cmd high)
// returns one stored entry, zero beyond the ring. Every accepted beat yields
// one result beat, and a new beat is taken each cycle while results are
// taken and no clear or fold runs. The store read lands in the cycle after
// acceptance; results pass through stage one and an output register. After
// reset the store is zeroed one entry per cycle, all min(DEPTH, 65536)
// entries, with s_ready low. A write of initial_length folds the write
// position into the new length with a bit-serial remainder unit, holding
// s_ready low while it runs; periods_per_capture writes take effect at once.
module period_tracking_capture_buffer #(
    parameter int DEPTH = 65536
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_cmd,
    input  logic [ptcb_pkg::PHASE_W-1:0]         s_phase,
    input  logic signed [ptcb_pkg::SAMPLE_W-1:0] s_sample,
    input  logic [ptcb_pkg::POS_W-1:0]           s_read_index,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [ptcb_pkg::SAMPLE_W-1:0] m_read_data,
    output logic [ptcb_pkg::LEN_W-1:0]           m_length,
    output logic [ptcb_pkg::POS_W-1:0]           m_write_pos,
    output logic                                 m_retriggered,
    input  logic                                 cfg_wr_en,
    input  logic [ptcb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ptcb_pkg::CFG_W-1:0]           cfg_wdata
);
    import ptcb_pkg::*;

    localparam int MAXLEN = (DEPTH < 65536) ? DEPTH : 65536;
    localparam int AW     = $clog2(MAXLEN);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAXLEN - 1);

    logic                accept;
    logic                s1_adv;
    logic                ctrl_busy;
    step_res_t           step_res;
    logic                step_we;
    logic [AW-1:0]       step_waddr;
    logic [SAMPLE_W-1:0] step_wdata;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [SAMPLE_W-1:0] ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [SAMPLE_W-1:0] ram_rdata;

    logic                clr_active_reg, clr_active_next;
    logic [AW-1:0]       clr_addr_reg, clr_addr_next;
    logic                s1_valid_reg, s1_valid_next;
    step_res_t           s1_res_reg;
    logic                m_valid_reg, m_valid_next;
    logic [SAMPLE_W-1:0] m_data_reg;
    logic [LEN_W-1:0]    m_len_reg;
    logic [POS_W-1:0]    m_pos_reg;
    logic                m_retrig_reg;

    // stage one may move on whenever the output register frees up
    assign s1_adv  = !m_valid_reg || m_ready;
    assign s_ready = !clr_active_reg && !ctrl_busy && (!s1_valid_reg || s1_adv);
    assign accept  = s_valid && s_ready;

    ptcb_ctrl #(
        .MAX_LEN (MAXLEN),
        .AW      (AW)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (accept),
        .s_cmd        (s_cmd),
        .s_phase      (s_phase),
        .s_sample     (s_sample),
        .s_read_index (s_read_index),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .res          (step_res),
        .busy         (ctrl_busy),
        .ram_we       (step_we),
        .ram_waddr    (step_waddr),
        .ram_wdata    (step_wdata),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr)
    );

    // clearing sweep owns the write port after reset
    always_comb begin
        if (clr_active_reg) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end else begin
            ram_we    = step_we;
            ram_waddr = step_waddr;
            ram_wdata = step_wdata;
        end
    end

    ptcb_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAXLEN)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg) begin
            if (clr_addr_reg == LAST_ADDR) begin
                clr_active_next = 1'b0;
            end else begin
                clr_addr_next = clr_addr_reg + AW'(1);
            end
        end

        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end

        if (s1_valid_reg && s1_adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            s1_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            s1_valid_reg   <= s1_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        if (accept) begin
            s1_res_reg <= step_res;
        end
        if (s1_valid_reg && s1_adv) begin
            m_data_reg   <= s1_res_reg.rd_hit ? ram_rdata : '0;
            m_len_reg    <= s1_res_reg.length;
            m_pos_reg    <= s1_res_reg.write_pos;
            m_retrig_reg <= s1_res_reg.retriggered;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_read_data   = m_data_reg;
    assign m_length      = m_len_reg;
    assign m_write_pos   = m_pos_reg;
    assign m_retriggered = m_retrig_reg;
endmodule

// ----- rtl/core/ptcb_checker.sv -----
// port-level checks of the capture buffer, bound to the top level
`include "period_tracking_capture_buffer_defines.svh"

module ptcb_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic signed [ptcb_pkg::SAMPLE_W-1:0] m_read_data,
    input logic [ptcb_pkg::LEN_W-1:0]           m_length,
    input logic [ptcb_pkg::POS_W-1:0]           m_write_pos,
    input logic                                 m_retriggered
);
    import ptcb_pkg::*;

    `PTCB_ASSERT(a_len_min, !m_valid || (m_length >= MIN_LEN), "ring length below two")
    `PTCB_ASSERT(a_pos_in_ring, !m_valid || ({1'b0, m_write_pos} < m_length), "pos outside ring")
    `PTCB_ASSERT(a_retrig_pos, !m_valid || !m_retriggered || (m_write_pos == 16'd1), "no restart")
    `PTCB_ASSERT(a_retrig_data, !m_valid || !m_retriggered || (m_read_data == '0), "read data set")
    `PTCB_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_length), "not held")
endmodule

bind period_tracking_capture_buffer ptcb_checker u_ptcb_checker (.*);
